// ===== design/ckim_pkg.sv =====
// Package for the clause key / proof id mapper: command and status codes,
// default sizes. No dependencies.
`timescale 1ns / 1ps
package ckim_pkg;
  localparam int unsigned DefEntries = 256;
  localparam int unsigned DefKeyBits = 32;
  localparam int unsigned DefIdBits = 32;
  localparam int unsigned FieldBits = 32;

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_ALIAS = 3'd2,
    CMD_RELOC = 3'd3,
    CMD_RETIRE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;
endpackage

// ===== design/clause_key_id_mapper.sv =====
// Clause key / proof id mapper, top level. Sequencer, scan unit and the two tables.
// Depends on ckim_pkg.
//
//  channel | direction | ports
//  --------+-----------+-------------------------------------------------------------
//  in_     | request   | in_valid/in_ready, command, key_valid, key, new_key_valid,
//          |           | new_key, retire_id
//  out_    | result    | out_valid/out_ready, result_id, status
//
// A scan pass visits one slot per cycle, forward and reverse side together. Table
// reads are registered, so a pass ends by draining the read stage. A retire that finds
// its id and a relocate that clears its checks run a second pass (forward slot of the
// retired key, or the reverse slot of the moved id). A single compare unit serves
// both passes, so slots are visited one at a time. in_ready is low from accept until
// the result has been taken; out_ready stalls keep it low.
// Reset clears the valid bits and the last-given id and sets the id counter to 1.
`timescale 1ns / 1ps
module clause_key_id_mapper #(
  parameter int unsigned TABLE_ENTRIES = ckim_pkg::DefEntries,
  parameter int unsigned KEY_BITS = ckim_pkg::DefKeyBits,
  parameter int unsigned ID_BITS = ckim_pkg::DefIdBits
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] in_command,
  input  logic in_key_valid,
  input  logic [ckim_pkg::FieldBits-1:0] in_key,
  input  logic in_new_key_valid,
  input  logic [ckim_pkg::FieldBits-1:0] in_new_key,
  input  logic [ckim_pkg::FieldBits-1:0] in_retire_id,
  output logic out_valid,
  input  logic out_ready,
  output logic [ckim_pkg::FieldBits-1:0] out_result_id,
  output logic [1:0] out_status
);
  import ckim_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = IW + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_CHECK  = 7'b0000100,  // first pass settled; rev_key read for retire
    S_SCAN2  = 7'b0001000,  // retire: forward slot of key; relocate: slot of id
    S_DECIDE = 7'b0010000,
    S_WRITE  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  logic [TABLE_ENTRIES-1:0] fwd_valid_r, rev_valid_r;
  logic [KEY_BITS-1:0] fwd_key_m [TABLE_ENTRIES];
  logic [ID_BITS-1:0]  fwd_id_m  [TABLE_ENTRIES];
  logic [ID_BITS-1:0]  rev_id_m  [TABLE_ENTRIES];
  logic [KEY_BITS-1:0] rev_key_m [TABLE_ENTRIES];

  state_t state_r;
  logic [2:0] cmd_r;
  logic kv_r, nkv_r;
  logic [KEY_BITS-1:0] k_r, nk_r, rk_r;
  logic [ID_BITS-1:0] rid_r, next_r, last_r, res_r;
  logic [1:0] st_r;
  logic [CW-1:0] idx_r;
  logic [IW-1:0] idx;
  // scan results
  logic fk_hit_r, fn_hit_r, ff_hit_r, rh_hit_r, rf_hit_r;
  logic [IW-1:0] fk_r, ff_r, rh_r, rf_r;
  logic [ID_BITS-1:0] fk_id_r, fn_id_r;
  logic [ID_BITS-1:0] rev_tgt;
  // registered read stage of the scan
  logic scan_on_r, rd_pass2_r, rd_fv_r, rd_rv_r;
  logic [KEY_BITS-1:0] rd_fkey_r;
  logic [ID_BITS-1:0] rd_fid_r, rd_rid_r;
  logic [IW-1:0] rd_slot_r;

  assign idx = idx_r[IW-1:0];
  assign in_ready = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign out_result_id = FieldBits'(res_r);
  assign out_status = st_r;

  // id the reverse scan looks for
  always_comb begin
    rev_tgt = rid_r;
    if (cmd_r == CMD_ALLOC) rev_tgt = next_r;
    else if (cmd_r == CMD_ALIAS) rev_tgt = last_r;
    else if (cmd_r == CMD_RELOC) rev_tgt = fk_id_r;
  end

  // the one compare unit: both tables at the slot held in the read stage
  logic [KEY_BITS-1:0] cmp_key;
  logic f_eq_k, f_eq_n, r_eq;
  assign cmp_key = rd_pass2_r ? rk_r : k_r;
  assign f_eq_k = rd_fv_r && rd_fkey_r == cmp_key;
  assign f_eq_n = rd_fv_r && rd_fkey_r == nk_r;
  assign r_eq = rd_rv_r && rd_rid_r == rev_tgt;

  // issue runs slots 0..TABLE_ENTRIES-1, then the read stage drains
  logic last_slot;
  assign last_slot = idx_r == CW'(TABLE_ENTRIES);

  logic reloc_ok, need_pass2;
  assign reloc_ok = kv_r && nkv_r && k_r != nk_r && fk_hit_r &&
                    (!fn_hit_r || fn_id_r == fk_id_r);
  assign need_pass2 = (cmd_r == CMD_RETIRE && rid_r != '0 && rh_hit_r) ||
                      (cmd_r == CMD_RELOC && reloc_ok);

  // decision made once the scans are settled
  logic do_w;
  logic [1:0] dec_st;
  logic [ID_BITS-1:0] dec_res;
  logic rslot_ok;
  logic [IW-1:0] rslot;
  always_comb begin
    do_w = 1'b0;
    dec_st = ST_IGNORED;
    dec_res = '0;
    rslot_ok = rh_hit_r || rf_hit_r;
    rslot = rh_hit_r ? rh_r : rf_r;
    unique case (cmd_r)
      CMD_ALLOC: if (kv_r) begin
        if (fk_hit_r) begin
          dec_res = fk_id_r; dec_st = ST_DONE;
        end else if (next_r == '0) dec_st = ST_EXHAUSTED;
        else if (!ff_hit_r || !rslot_ok) dec_st = ST_FULL;
        else begin
          do_w = 1'b1; dec_st = ST_DONE; dec_res = next_r;
        end
      end
      CMD_LOOKUP: if (kv_r && fk_hit_r) begin
        dec_res = fk_id_r; dec_st = ST_DONE;
      end
      CMD_ALIAS: if (kv_r && last_r != '0 && !fk_hit_r) begin
        if (!ff_hit_r || !rslot_ok) dec_st = ST_FULL;
        else begin
          do_w = 1'b1; dec_st = ST_DONE;
        end
      end
      CMD_RELOC: if (reloc_ok) begin
        if (!rslot_ok) dec_st = ST_FULL;
        else begin
          do_w = 1'b1; dec_st = ST_DONE;
        end
      end
      CMD_RETIRE: if (rid_r != '0 && rh_hit_r) begin
        do_w = 1'b1; dec_st = ST_DONE;
      end
      default: ;
    endcase
  end

  logic accept;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      scan_on_r <= 1'b0;
      fwd_valid_r <= '0;
      rev_valid_r <= '0;
      next_r <= ID_BITS'(1);
      last_r <= '0;
    end else begin
      scan_on_r <= (state_r == S_SCAN || state_r == S_SCAN2) && !last_slot;
      unique case (state_r)
        S_IDLE: if (accept) state_r <= S_SCAN;
        S_SCAN: if (last_slot) state_r <= S_CHECK;
        S_CHECK: begin
          if (need_pass2) state_r <= S_SCAN2;
          else begin
            st_r <= dec_st;
            res_r <= dec_res;
            state_r <= do_w ? S_WRITE : S_OUT;
          end
        end
        S_SCAN2: if (last_slot) state_r <= S_DECIDE;
        S_DECIDE: begin
          st_r <= dec_st;
          res_r <= dec_res;
          state_r <= do_w ? S_WRITE : S_OUT;
        end
        S_WRITE: begin
          unique case (cmd_r)
            CMD_ALLOC, CMD_ALIAS: begin
              fwd_valid_r[ff_r] <= 1'b1;
              rev_valid_r[rslot] <= 1'b1;
              if (cmd_r == CMD_ALLOC) begin
                last_r <= next_r;
                next_r <= next_r + ID_BITS'(1);
              end
            end
            CMD_RELOC: begin
              if (fn_hit_r) fwd_valid_r[fk_r] <= 1'b0;
              rev_valid_r[rslot] <= 1'b1;
            end
            default: begin
              if (rf_hit_r) fwd_valid_r[rf_r] <= 1'b0;
              rev_valid_r[rh_r] <= 1'b0;
            end
          endcase
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // registered table reads
  always_ff @(posedge clk) begin
    rd_fv_r <= fwd_valid_r[idx];
    rd_rv_r <= rev_valid_r[idx];
    rd_fkey_r <= fwd_key_m[idx];
    rd_fid_r <= fwd_id_m[idx];
    rd_rid_r <= rev_id_m[idx];
    rd_slot_r <= idx;
    rd_pass2_r <= state_r == S_SCAN2;
    rk_r <= rev_key_m[rh_r];
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      kv_r <= in_key_valid;
      nkv_r <= in_new_key_valid;
      k_r <= KEY_BITS'(in_key);
      nk_r <= KEY_BITS'(in_new_key);
      rid_r <= ID_BITS'(in_retire_id);
      idx_r <= '0;
      fk_hit_r <= 1'b0; fn_hit_r <= 1'b0; ff_hit_r <= 1'b0;
      rh_hit_r <= 1'b0; rf_hit_r <= 1'b0;
    end else begin
      if (state_r == S_SCAN || state_r == S_SCAN2)
        idx_r <= last_slot ? '0 : idx_r + CW'(1);
      if (state_r == S_CHECK && need_pass2) begin
        if (cmd_r == CMD_RETIRE) rf_hit_r <= 1'b0;  // reused: forward slot of retired key
        else rh_hit_r <= 1'b0;                      // relocate: search the moved id
      end
      if (scan_on_r && !rd_pass2_r) begin
        if (f_eq_k && !fk_hit_r) begin
          fk_hit_r <= 1'b1; fk_r <= rd_slot_r; fk_id_r <= rd_fid_r;
        end
        if (f_eq_n && !fn_hit_r) begin
          fn_hit_r <= 1'b1; fn_id_r <= rd_fid_r;
        end
        if (!rd_fv_r && !ff_hit_r) begin
          ff_hit_r <= 1'b1; ff_r <= rd_slot_r;
        end
        if (r_eq && !rh_hit_r) begin
          rh_hit_r <= 1'b1; rh_r <= rd_slot_r;
        end
        if (!rd_rv_r && !rf_hit_r) begin
          rf_hit_r <= 1'b1; rf_r <= rd_slot_r;
        end
      end
      if (scan_on_r && rd_pass2_r) begin
        if (cmd_r == CMD_RETIRE) begin
          if (f_eq_k && !rf_hit_r) begin
            rf_hit_r <= 1'b1; rf_r <= rd_slot_r;
          end
        end else if (r_eq && !rh_hit_r) begin
          rh_hit_r <= 1'b1; rh_r <= rd_slot_r;
        end
      end
    end
  end

  // table writes
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      if (cmd_r == CMD_ALLOC || cmd_r == CMD_ALIAS) begin
        fwd_key_m[ff_r] <= k_r;
        fwd_id_m[ff_r] <= (cmd_r == CMD_ALLOC) ? next_r : last_r;
      end else if (cmd_r == CMD_RELOC && !fn_hit_r) begin
        fwd_key_m[fk_r] <= nk_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE && cmd_r != CMD_RETIRE) begin
      rev_id_m[rslot] <= (cmd_r == CMD_ALLOC) ? next_r :
                         (cmd_r == CMD_ALIAS) ? last_r : fk_id_r;
      rev_key_m[rslot] <= (cmd_r == CMD_RELOC) ? nk_r : k_r;
    end
  end
endmodule

// ===== bench/clause_key_id_mapper_tb.sv =====
// Self-checking bench for clause_key_id_mapper: directed, table-full and random requests.
// An in-bench table model predicts every response. Depends on ckim_pkg and the RTL top.
`timescale 1ns / 1ps
module clause_key_id_mapper_tb;
  import ckim_pkg::*;

  localparam int Slots = DefEntries;
  localparam int ScanCycles = Slots + 8;         // one scan pass plus the write
  localparam longint CycleLimit = 2_000_000;

  typedef struct packed {
    logic [31:0] id;
    status_t     status;
  } response_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  logic [2:0] in_command;
  logic in_key_valid, in_new_key_valid;
  logic [31:0] in_key, in_new_key, in_retire_id;
  logic out_valid, out_ready;
  logic [31:0] out_result_id;
  logic [1:0] out_status;

  clause_key_id_mapper dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_key_valid(in_key_valid), .in_key(in_key),
    .in_new_key_valid(in_new_key_valid), .in_new_key(in_new_key),
    .in_retire_id(in_retire_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_id(out_result_id), .out_status(out_status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Mirror of the two tables, the id counter and the newest id handed out.
  logic        fwd_used [Slots];
  logic [31:0] fwd_key_m [Slots];
  logic [31:0] fwd_id_m [Slots];
  logic        rev_used [Slots];
  logic [31:0] rev_id_m [Slots];
  logic [31:0] rev_key_m [Slots];
  logic [31:0] id_counter;
  logic [31:0] newest_id;

  response_t pending_responses[$];
  int  mismatches = 0;
  bit  calm = 1'b0;              // no idling on either side
  longint cycles = 0;
  logic [31:0] key_pool [32];

  function automatic int find_key(logic [31:0] k);
    for (int i = 0; i < Slots; i++)
      if (fwd_used[i] && fwd_key_m[i] == k) return i;
    return -1;
  endfunction

  function automatic int free_fwd();
    for (int i = 0; i < Slots; i++)
      if (!fwd_used[i]) return i;
    return -1;
  endfunction

  // Slot already holding the id, else the lowest free slot.
  function automatic int rev_place(logic [31:0] id);
    int spare;
    spare = -1;
    for (int i = 0; i < Slots; i++) begin
      if (rev_used[i]) begin
        if (rev_id_m[i] == id) return i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    return spare;
  endfunction

  function automatic int find_id(logic [31:0] id);
    for (int i = 0; i < Slots; i++)
      if (rev_used[i] && rev_id_m[i] == id) return i;
    return -1;
  endfunction

  function automatic int fwd_count();
    int n;
    n = 0;
    for (int i = 0; i < Slots; i++) n += fwd_used[i];
    return n;
  endfunction

  // Applies one request to the mirror and returns the response it must produce.
  function automatic response_t map_request(logic [2:0] cmd, logic kv, logic [31:0] k,
                                            logic nkv, logic [31:0] nk, logic [31:0] rid);
    response_t r;
    int f, s, n;
    logic [31:0] moved;
    r = '{id: '0, status: ST_IGNORED};
    case (cmd)
      CMD_ALLOC: if (kv) begin
        f = find_key(k);
        if (f >= 0) begin
          r = '{id: fwd_id_m[f], status: ST_DONE};
        end else if (id_counter == 0) begin
          r.status = ST_EXHAUSTED;
        end else begin
          f = free_fwd();
          s = rev_place(id_counter);
          if (f < 0 || s < 0) begin
            r.status = ST_FULL;
          end else begin
            fwd_used[f] = 1; fwd_key_m[f] = k; fwd_id_m[f] = id_counter;
            rev_used[s] = 1; rev_id_m[s] = id_counter; rev_key_m[s] = k;
            r = '{id: id_counter, status: ST_DONE};
            newest_id = id_counter;
            id_counter = id_counter + 1;
          end
        end
      end
      CMD_LOOKUP: if (kv) begin
        f = find_key(k);
        if (f >= 0) r = '{id: fwd_id_m[f], status: ST_DONE};
      end
      CMD_ALIAS: if (kv && newest_id != 0 && find_key(k) < 0) begin
        f = free_fwd();
        s = rev_place(newest_id);
        if (f < 0 || s < 0) begin
          r.status = ST_FULL;
        end else begin
          fwd_used[f] = 1; fwd_key_m[f] = k; fwd_id_m[f] = newest_id;
          rev_used[s] = 1; rev_id_m[s] = newest_id; rev_key_m[s] = k;
          r.status = ST_DONE;
        end
      end
      CMD_RELOC: if (kv && nkv && k != nk) begin
        f = find_key(k);
        if (f >= 0) begin
          moved = fwd_id_m[f];
          n = find_key(nk);
          // refused when the new key already belongs to another id
          if (n < 0 || fwd_id_m[n] == moved) begin
            s = rev_place(moved);
            if (s < 0) begin
              r.status = ST_FULL;
            end else begin
              if (n < 0) fwd_key_m[f] = nk;
              else fwd_used[f] = 0;
              rev_used[s] = 1; rev_id_m[s] = moved; rev_key_m[s] = nk;
              r.status = ST_DONE;
            end
          end
        end
      end
      CMD_RETIRE: if (rid != 0) begin
        s = find_id(rid);
        if (s >= 0) begin
          f = find_key(rev_key_m[s]);
          if (f >= 0) fwd_used[f] = 0;
          rev_used[s] = 0;
          r.status = ST_DONE;
        end
      end
      default: ;                 // unknown command codes are ignored
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    mismatches++;
  endtask

  // Sends one request; in_valid stays high so back-to-back requests need no toggle.
  task automatic send_request(logic [2:0] cmd, logic kv, logic [31:0] k,
                              logic nkv, logic [31:0] nk, logic [31:0] rid);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_key_valid <= kv;
    in_key <= k;
    in_new_key_valid <= nkv;
    in_new_key <= nk;
    in_retire_id <= rid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_responses.push_back(map_request(cmd, kv, k, nkv, nk, rid));
  endtask

  // Result side: random stall bursts, none once the run turns calm.
  initial begin
    out_ready <= 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare every accepted response with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("unexpected response id", out_result_id, '0);
      end else begin
        response_t want;
        want = pending_responses.pop_front();
        if (out_result_id !== want.id) report_mismatch("result_id", out_result_id, want.id);
        if (out_status !== want.status)
          report_mismatch("status", {30'd0, out_status}, {30'd0, want.status});
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[clause_key_id_mapper] ERROR");
      $finish;
    end
  end

  // Extremes of every field, each command, the ignored cases, unknown codes.
  task automatic test_directed();
    send_request(CMD_ALIAS, 1, 32'd5, 0, 0, 0);              // nothing allocated yet
    send_request(CMD_ALLOC, 0, 32'd9, 0, 0, 0);              // invalid key
    send_request(CMD_ALLOC, 1, 32'd0, 0, 0, 0);
    send_request(CMD_ALLOC, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_ALLOC, 1, 32'd0, 0, 0, 0);              // existing key
    send_request(CMD_LOOKUP, 1, 32'd0, 0, 0, 0);
    send_request(CMD_LOOKUP, 1, 32'd77, 0, 0, 0);            // missing
    send_request(CMD_LOOKUP, 0, 32'd0, 0, 0, 0);
    send_request(CMD_ALIAS, 1, 32'd10, 0, 0, 0);
    send_request(CMD_ALIAS, 1, 32'd10, 0, 0, 0);             // already present
    send_request(CMD_RELOC, 1, 32'd0, 1, 32'd20, 0);
    send_request(CMD_RELOC, 0, 32'd20, 1, 32'd30, 0);
    send_request(CMD_RELOC, 1, 32'd20, 1, 32'd20, 0);        // equal keys
    send_request(CMD_RELOC, 1, 32'd44, 1, 32'd45, 0);        // old key missing
    send_request(CMD_RELOC, 1, 32'd20, 1, 32'hFFFF_FFFF, 0); // conflict, refused
    send_request(CMD_RELOC, 1, 32'd10, 1, 32'hFFFF_FFFF, 0); // same id, merges
    send_request(CMD_RETIRE, 0, 0, 0, 0, 32'd0);
    send_request(CMD_RETIRE, 0, 0, 0, 0, 32'd1);
    send_request(CMD_RETIRE, 0, 0, 0, 0, 32'd1);             // already gone
    send_request(CMD_RETIRE, 0, 0, 0, 0, 32'd99);
    for (int c = 5; c < 8; c++) send_request(3'(c), 1, 32'hFFFF_FFFF, 1, 32'd3, 32'd2);
  endtask

  // Fill the forward table, hit the full case, then drain it again.
  task automatic test_table_full();
    while (fwd_count() < Slots) send_request(CMD_ALLOC, 1, $urandom, 0, 0, 0);
    repeat (3) send_request(CMD_ALLOC, 1, $urandom, 0, 0, 0);
    send_request(CMD_ALIAS, 1, $urandom, 0, 0, 0);
    for (logic [31:0] id = 1; id < id_counter; id++) send_request(CMD_RETIRE, 0, 0, 0, 0, id);
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 6) == 0) ? $urandom : key_pool[$urandom_range(0, 31)];
  endfunction

  task automatic test_random(int count);
    int w;
    logic [2:0] cmd;
    logic [31:0] rid;
    for (int i = 0; i < count; i++) begin
      if (i > count - 120) calm = 1'b1;
      w = $urandom_range(0, 99);
      cmd = w < 30 ? CMD_ALLOC : w < 48 ? CMD_LOOKUP : w < 58 ? CMD_ALIAS :
            w < 74 ? CMD_RELOC : w < 95 ? CMD_RETIRE : 3'($urandom_range(5, 7));
      rid = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, id_counter);
      send_request(cmd, $urandom_range(0, 9) != 0, pick_key(),
                   $urandom_range(0, 9) != 0, pick_key(), rid);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_LOOKUP;
    in_key_valid <= 1'b0;
    in_key <= '0;
    in_new_key_valid <= 1'b0;
    in_new_key <= '0;
    in_retire_id <= '0;
    for (int i = 0; i < Slots; i++) begin
      fwd_used[i] = 0; rev_used[i] = 0;
      fwd_key_m[i] = '0; fwd_id_m[i] = '0; rev_id_m[i] = '0; rev_key_m[i] = '0;
    end
    id_counter = 1;
    newest_id = 0;
    key_pool[0] = '0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 32; i++) key_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_random(220);

    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (ScanCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("[clause_key_id_mapper] OK");
    end else begin
      $display("[clause_key_id_mapper] ERROR");
    end
    $finish;
  end
endmodule
